// ===== rtl/sbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

    // Coordinate width default and pixel color format
    localparam int COORD_BITS_DEF = 10;
    localparam int COLOR_BITS     = 24;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'h00FF00;

    // Style pattern repeats every lcm(2, 5, 6) pixels
    localparam int PAT_PERIOD = 30;
    localparam int PAT_BITS   = 5;

    // Draw masks, bit c set when pixel c of the period is drawn
    localparam logic [PAT_PERIOD-1:0] MASK_DOTTED   = 30'h15555555; // c mod 2 == 0
    localparam logic [PAT_PERIOD-1:0] MASK_DASHED   = 30'h318C6318; // c mod 5 in 3..4
    localparam logic [PAT_PERIOD-1:0] MASK_DASH_DOT = 30'h269A69A6; // c mod 6 in 1,2,5

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STYLE_SOLID    = 2'd0,
        STYLE_DOTTED   = 2'd1,
        STYLE_DASHED   = 2'd2,
        STYLE_DASH_DOT = 2'd3
    } t_style;

    typedef enum logic [1:0] {
        DIR_HOLD = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd2
    } t_dir;

endpackage

`default_nettype wire

// ===== rtl/sbl_line_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line command channel: load endpoints and style, or step one pixel
interface sbl_line_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [1:0]            style;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, style,
        input  ready
    );
    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, style,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sbl_pixel_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pixel result channel
interface sbl_pixel_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  draw;
    logic [23:0]           color;
    logic                  last;

    modport source (
        output valid, pixel_x, pixel_y, draw, color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, draw, color, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/sbl_pattern.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Line style sequencer: pixel index modulo the pattern period and draw lookup
module sbl_pattern
    import sbl_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_restart,
    input  wire [1:0] i_style,
    input  wire       i_advance,
    output logic      o_draw
);

    logic [PAT_BITS-1:0] r_count, n_count;
    t_style              r_style, n_style;

    // Next count: clear on a new line, wrap at the period end
    always_comb begin
        n_count = r_count;
        n_style = r_style;
        if (i_restart) begin
            n_count = '0;
            n_style = t_style'(i_style);
        end else if (i_advance) begin
            if (r_count == PAT_BITS'(PAT_PERIOD - 1)) begin
                n_count = '0;
            end else begin
                n_count = r_count + PAT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_style <= STYLE_SOLID;
        end else begin
            r_count <= n_count;
            r_style <= n_style;
        end
    end

    // Draw flag for the current pixel
    always_comb begin
        case (r_style)
            STYLE_SOLID:    o_draw = 1'b1;
            STYLE_DOTTED:   o_draw = MASK_DOTTED[r_count];
            STYLE_DASHED:   o_draw = MASK_DASHED[r_count];
            STYLE_DASH_DOT: o_draw = MASK_DASH_DOT[r_count];
            default:        o_draw = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/styled_bresenham_line_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Styled Bresenham line engine. A load item (action 0) latches both endpoints
// and a style and gives no result; each step item (action 1) then gives one
// pixel, starting at the start point, with a style draw flag, the configured
// color and a last flag; major-axis-length pixels per line, the far endpoint
// is not emitted, and a step with no active line gives nothing. The error
// term, coordinate and pattern updates are one register-to-register pass, so
// one item is accepted per cycle unless the output is stalled, and a pixel
// appears in the output register the cycle after its step. The output
// register keeps taking items while its pixel is taken in the same cycle.
// pixel_color may be written only while no line output is pending.
module styled_bresenham_line_core
    import sbl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    sbl_line_if.sink              i_line,
    sbl_pixel_if.source           o_pixel,
    input  wire                   i_cfg_wr_en,
    input  wire [COLOR_BITS-1:0]  i_cfg_wr_data
);

    localparam int ERR_BITS = COORD_BITS + 2;
    localparam int SUM_BITS = COORD_BITS + 3;

    // Line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [ERR_BITS-1:0]   r_err, n_err;
    logic [COORD_BITS-1:0] r_major, n_major;
    logic [COORD_BITS-1:0] r_minor, n_minor;
    t_dir                  r_x_dir, n_x_dir;
    t_dir                  r_y_dir, n_y_dir;
    logic                  r_swapped, n_swapped;
    logic [COORD_BITS-1:0] r_remaining, n_remaining;
    logic [COLOR_BITS-1:0] r_color;

    // Output register
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic                  r_out_draw;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                  r_out_last;

    logic accept, do_load, do_step, pat_draw, err_pos;

    logic [COORD_BITS-1:0] adx, ady;
    logic [SUM_BITS-1:0]   err_init, err_sum;

    function automatic logic [COORD_BITS-1:0] f_move(
        input logic [COORD_BITS-1:0] v,
        input t_dir                  dir
    );
        logic [COORD_BITS-1:0] res;
        case (dir)
            DIR_INC: res = v + COORD_BITS'(1);
            DIR_DEC: res = v - COORD_BITS'(1);
            default: res = v;
        endcase
        return res;
    endfunction

    // Handshake
    assign i_line.ready = !r_out_valid || o_pixel.ready;
    assign accept  = i_line.valid && i_line.ready;
    assign do_load = accept && (t_action'(i_line.action) == ACT_LOAD);
    assign do_step = accept && (t_action'(i_line.action) == ACT_STEP)
                     && (r_remaining != '0);

    // Load setup: deltas and initial error 2*minor - major
    always_comb begin
        adx = (i_line.x_end >= i_line.x_start) ? i_line.x_end - i_line.x_start
                                               : i_line.x_start - i_line.x_end;
        ady = (i_line.y_end >= i_line.y_start) ? i_line.y_end - i_line.y_start
                                               : i_line.y_start - i_line.y_end;
        if (ady > adx) begin
            err_init = {2'b00, adx, 1'b0} - {3'b000, ady};
        end else begin
            err_init = {2'b00, ady, 1'b0} - {3'b000, adx};
        end
    end

    // Step: error positive means a minor-axis move
    assign err_pos = !r_err[ERR_BITS-1] && (r_err != '0);
    assign err_sum = {r_err[ERR_BITS-1], r_err} + {2'b00, r_minor, 1'b0}
                     - (err_pos ? {2'b00, r_major, 1'b0} : SUM_BITS'(0));

    // Next line state
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_err       = r_err;
        n_major     = r_major;
        n_minor     = r_minor;
        n_x_dir     = r_x_dir;
        n_y_dir     = r_y_dir;
        n_swapped   = r_swapped;
        n_remaining = r_remaining;
        if (do_load) begin
            n_cur_x = i_line.x_start;
            n_cur_y = i_line.y_start;
            n_x_dir = (i_line.x_end > i_line.x_start) ? DIR_INC :
                      (i_line.x_end < i_line.x_start) ? DIR_DEC : DIR_HOLD;
            n_y_dir = (i_line.y_end > i_line.y_start) ? DIR_INC :
                      (i_line.y_end < i_line.y_start) ? DIR_DEC : DIR_HOLD;
            n_swapped   = (ady > adx);
            n_major     = (ady > adx) ? ady : adx;
            n_minor     = (ady > adx) ? adx : ady;
            n_remaining = (ady > adx) ? ady : adx;
            n_err       = err_init[ERR_BITS-1:0];
        end else if (do_step) begin
            if (r_swapped) begin
                n_cur_y = f_move(r_cur_y, r_y_dir);
                n_cur_x = err_pos ? f_move(r_cur_x, r_x_dir) : r_cur_x;
            end else begin
                n_cur_x = f_move(r_cur_x, r_x_dir);
                n_cur_y = err_pos ? f_move(r_cur_y, r_y_dir) : r_cur_y;
            end
            n_err       = err_sum[ERR_BITS-1:0];
            n_remaining = r_remaining - COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_err       <= '0;
            r_major     <= '0;
            r_minor     <= '0;
            r_x_dir     <= DIR_HOLD;
            r_y_dir     <= DIR_HOLD;
            r_swapped   <= 1'b0;
            r_remaining <= '0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_err       <= n_err;
            r_major     <= n_major;
            r_minor     <= n_minor;
            r_x_dir     <= n_x_dir;
            r_y_dir     <= n_y_dir;
            r_swapped   <= n_swapped;
            r_remaining <= n_remaining;
        end
    end

    // Color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    // Style pattern
    sbl_pattern u_pattern (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (do_load),
        .i_style   (i_line.style),
        .i_advance (do_step),
        .o_draw    (pat_draw)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_step) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_draw  <= pat_draw;
            r_out_color <= r_color;
            r_out_last  <= (r_remaining == COORD_BITS'(1));
        end
    end

    assign o_pixel.valid   = r_out_valid;
    assign o_pixel.pixel_x = r_out_x;
    assign o_pixel.pixel_y = r_out_y;
    assign o_pixel.draw    = r_out_draw;
    assign o_pixel.color   = r_out_color;
    assign o_pixel.last    = r_out_last;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sbl_pkg::*;

    localparam int CB             = COORD_BITS_DEF;
    localparam int COORD_MAX      = (1 << CB) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 150;
    localparam int STALL_AFTER    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int PHASE_ITEMS    = 275;

    typedef enum logic [1:0] {
        EXP_PRED,
        EXP_NONE,
        EXP_PIXEL
    } exp_kind_e;

    typedef struct packed {
        t_action         act;
        logic [CB-1:0]   xs;
        logic [CB-1:0]   ys;
        logic [CB-1:0]   xe;
        logic [CB-1:0]   ye;
        t_style          sty;
    } line_cmd_t;

    typedef struct packed {
        logic [CB-1:0]         x;
        logic [CB-1:0]         y;
        logic                  draw;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        line_cmd_t cmd;
        exp_kind_e kind;
        pixel_t    pix;
    } test_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [COLOR_BITS-1:0] cfg_wr_data;

    sbl_line_if  #(.COORD_BITS(CB)) line_bus ();
    sbl_pixel_if #(.COORD_BITS(CB)) pix_bus ();

    styled_bresenham_line_core #(
        .COORD_BITS (CB)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line        (line_bus),
        .o_pixel       (pix_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Line tracer state, mirrors the engine
    logic [CB-1:0]         ln_x        = '0;
    logic [CB-1:0]         ln_y        = '0;
    int                    ln_err      = 0;
    int                    ln_major    = 0;
    int                    ln_minor    = 0;
    int                    ln_xdir     = 0;
    int                    ln_ydir     = 0;
    bit                    ln_steep    = 1'b0;
    int                    ln_left     = 0;
    int                    ln_pat      = 0;
    t_style                ln_style    = STYLE_SOLID;
    logic [COLOR_BITS-1:0] pix_color   = COLOR_RESET;

    pixel_t pixel_q[$];
    int     mismatches  = 0;
    int     n_pixels    = 0;
    int     idle_cycles = 0;
    int     burst_left  = 1;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit style_on(t_style s, int c);
        case (s)
            STYLE_DOTTED:   return (c % 2) == 0;
            STYLE_DASHED:   return (c % 5) >= 3;
            STYLE_DASH_DOT: return (c % 6 == 1) || (c % 6 == 2) || (c % 6 == 5);
            default:        return 1'b1;
        endcase
    endfunction

    function automatic logic [CB-1:0] nudge(logic [CB-1:0] v, int d);
        if (d > 0) return v + CB'(1);
        if (d < 0) return v - CB'(1);
        return v;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    // Advance the tracer by one item; emitted says whether a pixel comes out
    function automatic void trace_step(input line_cmd_t c, output pixel_t p,
                                       output bit emitted);
        int adx;
        int ady;
        p       = '0;
        emitted = 1'b0;
        if (c.act == ACT_LOAD) begin
            adx      = (c.xe >= c.xs) ? int'(c.xe) - int'(c.xs) : int'(c.xs) - int'(c.xe);
            ady      = (c.ye >= c.ys) ? int'(c.ye) - int'(c.ys) : int'(c.ys) - int'(c.ye);
            ln_xdir  = (c.xe > c.xs) ? 1 : ((c.xe < c.xs) ? -1 : 0);
            ln_ydir  = (c.ye > c.ys) ? 1 : ((c.ye < c.ys) ? -1 : 0);
            ln_steep = ady > adx;
            ln_major = ln_steep ? ady : adx;
            ln_minor = ln_steep ? adx : ady;
            ln_x     = c.xs;
            ln_y     = c.ys;
            ln_err   = 2 * ln_minor - ln_major;
            ln_left  = ln_major;
            ln_pat   = 0;
            ln_style = c.sty;
            return;
        end
        if (ln_left == 0) return;
        emitted = 1'b1;
        p.x     = ln_x;
        p.y     = ln_y;
        p.draw  = style_on(ln_style, ln_pat);
        p.color = pix_color;
        p.last  = (ln_left == 1);
        // minor step on positive error, then major step
        if (ln_err > 0) begin
            if (ln_steep) ln_x = nudge(ln_x, ln_xdir);
            else          ln_y = nudge(ln_y, ln_ydir);
            ln_err -= 2 * ln_major;
        end
        if (ln_steep) ln_y = nudge(ln_y, ln_ydir);
        else          ln_x = nudge(ln_x, ln_xdir);
        ln_err += 2 * ln_minor;
        ln_pat  = (ln_pat + 1) % PAT_PERIOD;
        ln_left--;
    endfunction

    function automatic line_cmd_t rand_cmd();
        line_cmd_t c;
        c.act = t_action'($urandom_range(0, 1));
        c.xs  = CB'($urandom_range(0, COORD_MAX));
        c.ys  = CB'($urandom_range(0, COORD_MAX));
        c.xe  = CB'($urandom_range(0, COORD_MAX));
        c.ye  = CB'($urandom_range(0, COORD_MAX));
        c.sty = t_style'($urandom_range(0, 3));
        return c;
    endfunction

    function automatic test_row_t row(exp_kind_e k, t_action a, int xs, int ys, int xe,
                                      int ye, t_style s, int px = 0, int py = 0,
                                      bit d = 1'b0, bit l = 1'b0);
        test_row_t r;
        r.cmd       = '{act: a, xs: CB'(xs), ys: CB'(ys), xe: CB'(xe), ye: CB'(ye), sty: s};
        r.kind      = k;
        r.pix.x     = CB'(px);
        r.pix.y     = CB'(py);
        r.pix.draw  = d;
        r.pix.color = COLOR_RESET;
        r.pix.last  = l;
        return r;
    endfunction

    // Offer one item, wait for acceptance, log what it should produce
    task automatic send_cmd(input line_cmd_t c, input exp_kind_e k, input pixel_t typed_px);
        pixel_t px;
        bit     emitted;
        int     gap;
        line_bus.valid   <= 1'b1;
        line_bus.action  <= c.act;
        line_bus.x_start <= c.xs;
        line_bus.y_start <= c.ys;
        line_bus.x_end   <= c.xe;
        line_bus.y_end   <= c.ye;
        line_bus.style   <= c.sty;
        do @(posedge i_clk); while (!line_bus.ready);
        trace_step(c, px, emitted);
        if (k == EXP_PIXEL)
            pixel_q.push_back(typed_px);
        else if (k == EXP_PRED && emitted)
            pixel_q.push_back(px);
        // bursts with random gaps, some bursts back to back
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                line_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering, let every pixel drain, then let a trailing load finish
    task automatic quiesce();
        line_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [COLOR_BITS-1:0] c);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        pix_color    = c;
    endtask

    // Mostly load-then-step sequences of short lines, some noise and cut lines
    task automatic run_phase(input int n_items);
        int        sent;
        int        r;
        int        dx;
        int        dy;
        int        major;
        int        nsteps;
        line_cmd_t c;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            c = rand_cmd();
            if (r < 8) begin
                send_cmd(c, EXP_PRED, '0);
                sent++;
            end else begin
                c.act = ACT_LOAD;
                if (r >= 14) begin
                    if ($urandom_range(0, 7) == 0) c.xs = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    if ($urandom_range(0, 7) == 0) c.ys = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    dx = $urandom_range(0, 12);
                    dy = $urandom_range(0, 12);
                    if ($urandom_range(0, 5) == 0) begin
                        if ($urandom_range(0, 1) != 0) dx = 0;
                        else                           dy = 0;
                    end
                    if ($urandom_range(0, 1) != 0) dx = -dx;
                    if ($urandom_range(0, 1) != 0) dy = -dy;
                    c.xe = CB'(clamp_coord(int'(c.xs) + dx));
                    c.ye = CB'(clamp_coord(int'(c.ys) + dy));
                end
                dx    = (c.xe >= c.xs) ? int'(c.xe) - int'(c.xs) : int'(c.xs) - int'(c.xe);
                dy    = (c.ye >= c.ys) ? int'(c.ye) - int'(c.ys) : int'(c.ys) - int'(c.ye);
                major = (dx > dy) ? dx : dy;
                if (major > 40)
                    nsteps = $urandom_range(5, 40);
                else if ($urandom_range(0, 4) == 0)
                    nsteps = $urandom_range(0, major);
                else
                    nsteps = major + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
                send_cmd(c, EXP_PRED, '0);
                sent++;
                for (int i = 0; i < nsteps; i++) begin
                    c     = rand_cmd();
                    c.act = ACT_STEP;
                    send_cmd(c, EXP_PRED, '0);
                    if (i < major) sent++;
                end
            end
        end
    endtask

    // Receiver: changing stall patterns, one long hold-off to back up the input
    initial begin
        int  rx_tick;
        int  rx_mode;
        bit  held;
        rx_tick      = 0;
        rx_mode      = 0;
        held         = 1'b0;
        pix_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_tick++;
            if (!held && n_pixels >= STALL_AFTER) begin
                held = 1'b1;
                pix_bus.ready <= 1'b0;
                repeat (LONG_STALL - 1) @(posedge i_clk);
            end else begin
                if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0:       pix_bus.ready <= 1'b1;
                    1:       pix_bus.ready <= 1'($urandom_range(0, 1));
                    2:       pix_bus.ready <= (rx_tick % 4 == 0);
                    default: pix_bus.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Pixel checker and watchdog
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && ((line_bus.valid && line_bus.ready) || (pix_bus.valid && pix_bus.ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            n_pixels++;
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel x=%0d y=%0d draw=%0b color=%06h last=%0b",
                             pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.draw,
                             pix_bus.color, pix_bus.last);
            end else begin
                want = pixel_q.pop_front();
                if (pix_bus.pixel_x !== want.x || pix_bus.pixel_y !== want.y ||
                    pix_bus.draw !== want.draw || pix_bus.color !== want.color ||
                    pix_bus.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: exp x=%0d y=%0d draw=%0b color=%06h ",
                                  "last=%0b, got x=%0d y=%0d draw=%0b color=%06h last=%0b"},
                                 want.x, want.y, want.draw, want.color, want.last,
                                 pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.draw,
                                 pix_bus.color, pix_bus.last);
                end
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("styled_bresenham_line_core verification failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        test_row_t rows[$];
        line_bus.valid   = 1'b0;
        line_bus.action  = ACT_LOAD;
        line_bus.x_start = '0;
        line_bus.y_start = '0;
        line_bus.x_end   = '0;
        line_bus.y_end   = '0;
        line_bus.style   = STYLE_SOLID;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        i_rst_n          = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // step with nothing loaded
        rows.push_back(row(EXP_NONE, ACT_STEP, 1023, 1023, 1023, 1023, STYLE_DASH_DOT));
        // zero-length line
        rows.push_back(row(EXP_NONE, ACT_LOAD, 0, 0, 0, 0, STYLE_SOLID));
        rows.push_back(row(EXP_NONE, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        // top corner, going down and left, dash-dot gap first
        rows.push_back(row(EXP_NONE, ACT_LOAD, 1023, 1023, 1020, 1022, STYLE_DASH_DOT));
        rows.push_back(row(EXP_PIXEL, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID,
                           1023, 1023, 1'b0, 1'b0));
        rows.push_back(row(EXP_PRED, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        rows.push_back(row(EXP_PRED, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        rows.push_back(row(EXP_NONE, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        // steep line, dashed
        rows.push_back(row(EXP_NONE, ACT_LOAD, 0, 0, 2, 5, STYLE_DASHED));
        for (int i = 0; i < 5; i++)
            rows.push_back(row(EXP_PRED, ACT_STEP, 1023, 0, 1023, 0, STYLE_DASH_DOT));
        // single-pixel line
        rows.push_back(row(EXP_NONE, ACT_LOAD, 5, 5, 4, 5, STYLE_SOLID));
        rows.push_back(row(EXP_PIXEL, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID, 5, 5, 1'b1, 1'b1));
        // dotted line dropped midway by a new load
        rows.push_back(row(EXP_NONE, ACT_LOAD, 10, 10, 20, 12, STYLE_DOTTED));
        rows.push_back(row(EXP_PIXEL, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID,
                           10, 10, 1'b1, 1'b0));
        rows.push_back(row(EXP_PRED, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        rows.push_back(row(EXP_NONE, ACT_LOAD, 0, 1023, 3, 1020, STYLE_SOLID));
        for (int i = 0; i < 3; i++)
            rows.push_back(row(EXP_PRED, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));
        // vertical line
        rows.push_back(row(EXP_NONE, ACT_LOAD, 512, 0, 512, 4, STYLE_DOTTED));
        rows.push_back(row(EXP_PRED, ACT_STEP, 0, 0, 0, 0, STYLE_SOLID));

        foreach (rows[i])
            send_cmd(rows[i].cmd, rows[i].kind, rows[i].pix);

        // random phases, each under its own color
        quiesce();
        write_color(24'hFFFFFF);
        run_phase(PHASE_ITEMS);
        quiesce();
        write_color(24'h000000);
        run_phase(PHASE_ITEMS);
        quiesce();
        write_color(COLOR_BITS'($urandom));
        run_phase(PHASE_ITEMS);
        quiesce();
        write_color(COLOR_BITS'($urandom));
        run_phase(PHASE_ITEMS);
        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pixel_q.size() == 0)
            $display("styled_bresenham_line_core verification clean");
        else
            $display("styled_bresenham_line_core verification failed");
        $finish;
    end

endmodule
